FILE: hdl/dcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcm_pkg
// Shared constants, register indexes, pipeline flags and a level helper for
// the depth colormap core.
// ----------------------------------------------------------------------------
package dcm_pkg;

  localparam int DEPTH_BITS_DEFAULT = 16;
  localparam int CFG_INDEX_W        = 2;
  localparam int CFG_DATA_W         = 32;
  localparam int BOUND_W            = 16;
  localparam int SCALE_W            = 32;
  localparam int LEVEL_W            = 16;
  localparam int COLOR_W            = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DEPTH_LO   = 2'd0,
    REG_DEPTH_HI   = 2'd1,
    REG_NORM_SCALE = 2'd2
  } cfg_reg_t;

  localparam logic [BOUND_W-1:0] DEPTH_LO_RESET   = 16'd0;
  localparam logic [BOUND_W-1:0] DEPTH_HI_RESET   = 16'hFFFF;
  localparam logic [SCALE_W-1:0] NORM_SCALE_RESET = 32'd65537;

  localparam logic [LEVEL_W-1:0] LEVEL_M = 16'd16384;
  localparam logic [LEVEL_W-1:0] LEVEL_V = 16'd49152;
  localparam logic [31:0]        VSF_Q32 = 32'd2147591022;

  localparam logic [COLOR_W-1:0] COLOR_WHITE = 32'hFFFF_FFFF;
  localparam logic [COLOR_W-1:0] COLOR_BLACK = 32'hFF00_0000;
  localparam logic [7:0]         ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    logic white;
    logic black;
    logic eof;
  } dcm_flags_t;

  // (level * 255) >> 16, truncated
  function automatic logic [7:0] level_to_byte(input logic [LEVEL_W-1:0] level);
    logic [23:0] prod;
    prod = {level, 8'b0} - {8'b0, level};
    return prod[23:16];
  endfunction

endpackage

FILE: hdl/dcm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcm interfaces
// Stream channels for depth pixels and colors, and the register write
// channel of the depth colormap core.
// ----------------------------------------------------------------------------
interface dcm_pixel_if #(parameter int DEPTH_BITS = 16) ();
  logic                  valid;
  logic                  ready;
  logic [DEPTH_BITS-1:0] depth;
  logic                  end_of_frame;

  modport source (output valid, depth, end_of_frame, input ready);
  modport sink   (input valid, depth, end_of_frame, output ready);
endinterface

interface dcm_color_if ();
  logic        valid;
  logic        ready;
  logic [31:0] color;
  logic        end_of_frame_out;

  modport source (output valid, color, end_of_frame_out, input ready);
  modport sink   (input valid, color, end_of_frame_out, output ready);
endinterface

interface dcm_cfg_if ();
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/dcm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcm_front
// Stage 1 classifies the depth against the bounds and subtracts the minimum;
// stage 2 multiplies the offset by the reciprocal range scale.
// ----------------------------------------------------------------------------
module dcm_front import dcm_pkg::*; #(
  parameter int DEPTH_BITS = DEPTH_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [DEPTH_BITS-1:0]  depth,
  input  logic                   end_of_frame,
  input  logic [BOUND_W-1:0]     depth_lo,
  input  logic [BOUND_W-1:0]     depth_hi,
  input  logic [SCALE_W-1:0]     norm_scale,
  output logic                   out_valid,
  input  logic                   out_ready,
  output dcm_flags_t             out_flags,
  output logic [DEPTH_BITS+31:0] out_product
);

  localparam int PW = DEPTH_BITS + SCALE_W;

  logic [31:0]           min_ext;
  logic [31:0]           max_ext;
  logic [DEPTH_BITS-1:0] lo;
  logic [DEPTH_BITS-1:0] hi;

  logic                  s1_valid;
  logic                  s1_ready;
  dcm_flags_t            s1_flags;
  logic [DEPTH_BITS-1:0] s1_diff;
  logic                  s2_ready;
  logic [PW-1:0]         product_next;

  assign min_ext = {16'b0, depth_lo};
  assign max_ext = {16'b0, depth_hi};
  assign lo      = min_ext[DEPTH_BITS-1:0];
  assign hi      = max_ext[DEPTH_BITS-1:0];

  assign s2_ready = !out_valid || out_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
    if (s1_ready && in_valid) begin
      s1_flags.white <= depth < lo;
      s1_flags.black <= depth >= hi;
      s1_flags.eof   <= end_of_frame;
      s1_diff        <= depth - lo;
    end
  end

  assign product_next = PW'(s1_diff) * PW'(norm_scale);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s1_valid;
    end
    if (s2_ready && s1_valid) begin
      out_flags   <= s1_flags;
      out_product <= product_next;
    end
  end

endmodule

FILE: hdl/dcm_hue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcm_hue
// Stage 3 splits the normalized depth into sextant and fraction, stage 4
// scales the fraction, stage 5 builds the ramp levels and packs RGBA.
// ----------------------------------------------------------------------------
module dcm_hue import dcm_pkg::*; #(
  parameter int DEPTH_BITS = DEPTH_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  dcm_flags_t             in_flags,
  input  logic [DEPTH_BITS+31:0] in_product,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [COLOR_W-1:0]     color,
  output logic                   end_of_frame_out
);

  localparam int PW = DEPTH_BITS + SCALE_W;

  logic [LEVEL_W-1:0] h16;
  logic               h_big;
  logic [18:0]        t;

  logic               s3_valid;
  logic               s3_ready;
  dcm_flags_t         s3_flags;
  logic [2:0]         s3_sextant;
  logic [LEVEL_W-1:0] s3_fract;

  logic               s4_valid;
  logic               s4_ready;
  dcm_flags_t         s4_flags;
  logic [2:0]         s4_sextant;
  logic [LEVEL_W-1:0] s4_vsf;
  logic [47:0]        vsf_prod;

  logic               s5_ready;
  logic [LEVEL_W-1:0] mid1;
  logic [LEVEL_W-1:0] mid2;
  logic [LEVEL_W-1:0] lev_r;
  logic [LEVEL_W-1:0] lev_g;
  logic [LEVEL_W-1:0] lev_b;
  logic               ramp_black;
  logic [COLOR_W-1:0] color_next;

  assign s5_ready = !out_valid || out_ready;
  assign s4_ready = !s4_valid || s5_ready;
  assign s3_ready = !s3_valid || s4_ready;
  assign in_ready = s3_ready;

  assign h16   = in_product[31:16];
  assign h_big = |in_product[PW-1:32];
  assign t     = 19'(h16) * 19'd6;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= in_valid;
    end
    if (s3_ready && in_valid) begin
      s3_flags.white <= in_flags.white;
      s3_flags.black <= in_flags.black || h_big;
      s3_flags.eof   <= in_flags.eof;
      s3_sextant     <= t[18:16];
      s3_fract       <= t[15:0];
    end
  end

  assign vsf_prod = 48'(s3_fract) * 48'(VSF_Q32);

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (s4_ready) begin
      s4_valid <= s3_valid;
    end
    if (s4_ready && s3_valid) begin
      s4_flags   <= s3_flags;
      s4_sextant <= s3_sextant;
      s4_vsf     <= vsf_prod[47:32];
    end
  end

  assign mid1 = LEVEL_M + s4_vsf;
  assign mid2 = LEVEL_V - s4_vsf;

  always_comb begin
    ramp_black = 1'b0;
    lev_r      = LEVEL_M;
    lev_g      = LEVEL_M;
    lev_b      = LEVEL_M;
    unique case (s4_sextant)
      3'd0: begin lev_r = LEVEL_V; lev_g = mid1;    lev_b = LEVEL_M; end
      3'd1: begin lev_r = mid2;    lev_g = LEVEL_V; lev_b = LEVEL_M; end
      3'd2: begin lev_r = LEVEL_M; lev_g = LEVEL_V; lev_b = mid1;    end
      3'd3: begin lev_r = LEVEL_M; lev_g = mid2;    lev_b = LEVEL_V; end
      3'd4: begin lev_r = mid1;    lev_g = LEVEL_M; lev_b = LEVEL_V; end
      3'd5: begin lev_r = LEVEL_V; lev_g = LEVEL_M; lev_b = mid2;    end
      default: ramp_black = 1'b1;
    endcase
  end

  always_comb begin
    priority if (s4_flags.white) begin
      color_next = COLOR_WHITE;
    end else if (s4_flags.black || ramp_black) begin
      color_next = COLOR_BLACK;
    end else begin
      color_next = {ALPHA_OPAQUE, level_to_byte(lev_b), level_to_byte(lev_g),
                    level_to_byte(lev_r)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s5_ready) begin
      out_valid <= s4_valid;
    end
    if (s5_ready && s4_valid) begin
      color            <= color_next;
      end_of_frame_out <= s4_flags.eof;
    end
  end

endmodule

FILE: hdl/depth_to_color_map_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_to_color_map_core
// Colorizes a stream of depth pixels into packed RGBA with a hue ramp.
//
// Channels: pixels (sink) carries depth and end_of_frame; colors (source)
// carries color (alpha 31:24, red 7:0) and end_of_frame_out; cfg is a
// register write channel (index 0 lower bound, 1 upper bound, 2 scale,
// where scale = 2^32 / (upper bound - lower bound)). cfg is always ready;
// write registers only while no request is in flight.
// Pipeline: five register stages (compare, scale multiply, sextant split,
// fraction multiply, pack); the first is loaded by the edge that accepts a
// pixel request, and the color is valid from the last. Throughput: one pixel
// per cycle while colors is ready (see Stall).
// Reset: clears every stage valid and loads bounds 0 and 65535, scale 65537.
// Stall: when colors is not ready each stage holds its request; the
// pipeline keeps taking pixels until every stage is full, then drops ready.
// ----------------------------------------------------------------------------
module depth_to_color_map_core import dcm_pkg::*; #(
  parameter int DEPTH_BITS = DEPTH_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  dcm_pixel_if.sink  pixels,
  dcm_color_if.source colors,
  dcm_cfg_if.sink    cfg
);

  logic [BOUND_W-1:0]     depth_lo;
  logic [BOUND_W-1:0]     depth_hi;
  logic [SCALE_W-1:0]     norm_scale;

  logic                   mid_valid;
  logic                   mid_ready;
  dcm_flags_t             mid_flags;
  logic [DEPTH_BITS+31:0] mid_product;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_lo   <= DEPTH_LO_RESET;
      depth_hi   <= DEPTH_HI_RESET;
      norm_scale <= NORM_SCALE_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_DEPTH_LO:   depth_lo   <= cfg.data[BOUND_W-1:0];
        REG_DEPTH_HI:   depth_hi   <= cfg.data[BOUND_W-1:0];
        REG_NORM_SCALE: norm_scale <= cfg.data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  dcm_front #(.DEPTH_BITS(DEPTH_BITS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (pixels.valid),
    .in_ready    (pixels.ready),
    .depth       (pixels.depth),
    .end_of_frame(pixels.end_of_frame),
    .depth_lo    (depth_lo),
    .depth_hi    (depth_hi),
    .norm_scale  (norm_scale),
    .out_valid   (mid_valid),
    .out_ready   (mid_ready),
    .out_flags   (mid_flags),
    .out_product (mid_product)
  );

  dcm_hue #(.DEPTH_BITS(DEPTH_BITS)) u_hue (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (mid_valid),
    .in_ready        (mid_ready),
    .in_flags        (mid_flags),
    .in_product      (mid_product),
    .out_valid       (colors.valid),
    .out_ready       (colors.ready),
    .color           (colors.color),
    .end_of_frame_out(colors.end_of_frame_out)
  );

  a_reset_values: assert property (@(posedge clk)
    rst |=> (depth_lo == DEPTH_LO_RESET && depth_hi == DEPTH_HI_RESET &&
             norm_scale == NORM_SCALE_RESET))
    else $error("register reset values not loaded");

  a_scale_write: assert property (@(posedge clk)
    (!rst && cfg.valid && cfg.ready && cfg.index == REG_NORM_SCALE)
      |=> norm_scale == $past(cfg.data))
    else $error("scale write lost");

  a_min_write: assert property (@(posedge clk)
    (!rst && cfg.valid && cfg.ready && cfg.index == REG_DEPTH_LO)
      |=> depth_lo == $past(cfg.data[BOUND_W-1:0]))
    else $error("lower bound write lost");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !colors.valid && !mid_valid)
    else $error("pipeline valid set after reset");

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for depth_to_color_map_core. Drives depth pixels under
// several bound and scale settings, predicts each packed RGBA color and
// compares every color request (color and end_of_frame_out) in order of arrival.
// ----------------------------------------------------------------------------
module tb_top;
  import dcm_pkg::*;

  class colormap_checker;
    logic [15:0] lo_bound;
    logic [15:0] hi_bound;
    logic [31:0] scale;
    logic [31:0] want_color[$];
    logic        want_eof[$];
    int          errors;

    function new();
      lo_bound = DEPTH_LO_RESET;
      hi_bound = DEPTH_HI_RESET;
      scale    = NORM_SCALE_RESET;
      errors   = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [31:0] data);
      case (idx)
        REG_DEPTH_LO:   lo_bound = data[15:0];
        REG_DEPTH_HI:   hi_bound = data[15:0];
        REG_NORM_SCALE: scale = data;
        default: ;
      endcase
    endfunction

    function logic [7:0] level_byte(logic [15:0] lvl);
      logic [31:0] p;
      p = {16'b0, lvl} * 32'd255;
      return p[23:16];
    endfunction

    function logic [31:0] rgba(logic [15:0] r, logic [15:0] g, logic [15:0] b);
      return {ALPHA_OPAQUE, level_byte(b), level_byte(g), level_byte(r)};
    endfunction

    function logic [31:0] colorize(logic [15:0] d);
      logic [63:0] h;
      logic [63:0] t;
      logic [63:0] prod;
      logic [15:0] fract;
      logic [15:0] vsf;
      logic [15:0] mid1;
      logic [15:0] mid2;
      if (d < lo_bound) return COLOR_WHITE;
      if (d >= hi_bound) return COLOR_BLACK;
      h = ({48'b0, d} - {48'b0, lo_bound}) * {32'b0, scale};
      h = h >> 16;
      t = h * 64'd6;
      fract = t[15:0];
      prod = {48'b0, fract} * {32'b0, VSF_Q32};
      vsf = prod[47:32];
      mid1 = LEVEL_M + vsf;
      mid2 = LEVEL_V - vsf;
      case (t[63:16])
        0: return rgba(LEVEL_V, mid1, LEVEL_M);
        1: return rgba(mid2, LEVEL_V, LEVEL_M);
        2: return rgba(LEVEL_M, LEVEL_V, mid1);
        3: return rgba(LEVEL_M, mid2, LEVEL_V);
        4: return rgba(mid1, LEVEL_M, LEVEL_V);
        5: return rgba(LEVEL_V, LEVEL_M, mid2);
        default: return COLOR_BLACK;
      endcase
    endfunction

    function void note_pixel(logic [15:0] d, logic eof);
      want_color.push_back(colorize(d));
      want_eof.push_back(eof);
    endfunction

    function void check_color(logic [31:0] color, logic eof);
      logic [31:0] c;
      logic        e;
      if (want_color.size() == 0) begin
        $display("%0t: unexpected color request: color %h eof %b", $time, color, eof);
        errors++;
        return;
      end
      c = want_color.pop_front();
      e = want_eof.pop_front();
      if (color !== c) begin
        $display("%0t: color mismatch: expected %h actual %h", $time, c, color);
        errors++;
      end
      if (eof !== e) begin
        $display("%0t: end_of_frame_out mismatch: expected %b actual %b", $time, e, eof);
        errors++;
      end
    endfunction

    function int pending();
      return want_color.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   quiet;
  logic [15:0] cur_lo;
  logic [15:0] cur_hi;
  colormap_checker chk = new();

  dcm_pixel_if #(.DEPTH_BITS(16)) pix ();
  dcm_color_if col ();
  dcm_cfg_if cfg_ch ();

  depth_to_color_map_core #(.DEPTH_BITS(16)) dut (
    .clk    (clk),
    .rst    (rst),
    .pixels (pix),
    .colors (col),
    .cfg    (cfg_ch)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  task automatic send_pixel(logic [15:0] d, logic eof);
    int gaps;
    gaps = 0;
    while (!quiet && $urandom_range(0, 99) < 17) gaps++;
    if (gaps > 0) begin
      pix.valid <= 1'b0;
      repeat (gaps) @(posedge clk);
    end
    pix.valid        <= 1'b1;
    pix.depth        <= d;
    pix.end_of_frame <= eof;
    do @(posedge clk); while (!pix.ready);
    chk.note_pixel(d, eof);
  endtask

  // hold off until every color is back and the pipeline has emptied
  task automatic drain();
    pix.valid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_one(cfg_reg_t idx, logic [31:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    chk.write_reg(idx, data);
  endtask

  task automatic set_bounds(logic [15:0] lo, logic [15:0] hi, logic [31:0] sc);
    drain();
    write_one(REG_DEPTH_LO, {16'b0, lo});
    write_one(REG_DEPTH_HI, {16'b0, hi});
    write_one(REG_NORM_SCALE, sc);
    cfg_ch.valid <= 1'b0;
    cur_lo = lo;
    cur_hi = hi;
  endtask

  function automatic logic [31:0] recip_scale(int unsigned span);
    logic [63:0] q;
    if (span == 0) return 32'hFFFF_FFFF;
    q = 64'h1_0000_0000 / span;
    if (q > 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
    return q[31:0];
  endfunction

  function automatic logic [15:0] pick_depth();
    int unsigned r;
    logic [15:0] edges[6];
    r = $urandom_range(0, 9);
    edges[0] = cur_lo - 16'd1;
    edges[1] = cur_lo;
    edges[2] = cur_lo + 16'd1;
    edges[3] = cur_hi - 16'd1;
    edges[4] = cur_hi;
    edges[5] = cur_hi + 16'd1;
    if (r <= 5 && cur_lo < cur_hi) return 16'($urandom_range(cur_lo, cur_hi - 1));
    if (r <= 7) return edges[$urandom_range(0, 5)];
    return 16'($urandom_range(0, 65535));
  endfunction

  // color side: check on each accepted request, then pick the next ready
  initial begin
    col.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && col.valid && col.ready) chk.check_color(col.color, col.end_of_frame_out);
      col.ready <= quiet || ($urandom_range(0, 99) >= 17);
    end
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int unsigned mode;
    int unsigned lo;
    int unsigned hi;
    logic [31:0] sc;
    logic [15:0] sweep[14];
    rst              <= 1'b1;
    quiet            = 1'b0;
    pix.valid        <= 1'b0;
    pix.depth        <= '0;
    pix.end_of_frame <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= REG_DEPTH_LO;
    cfg_ch.data      <= '0;
    cur_lo = DEPTH_LO_RESET;
    cur_hi = DEPTH_HI_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset settings: extremes and sextant boundaries
    sweep = '{16'd0, 16'd1, 16'd10922, 16'd10923, 16'd21845, 16'd21846, 16'd32768,
              16'd43690, 16'd43691, 16'd54613, 16'd54614, 16'd65534, 16'd65535,
              16'hAAAA};
    foreach (sweep[i]) send_pixel(sweep[i], i[0]);

    // bounds equal
    set_bounds(16'd1000, 16'd1000, 32'd0);
    send_pixel(16'd999, 1'b0);
    send_pixel(16'd1000, 1'b0);
    send_pixel(16'd1001, 1'b1);

    // bounds crossed
    set_bounds(16'd5000, 16'd100, recip_scale(4900));
    send_pixel(16'd4999, 1'b0);
    send_pixel(16'd5000, 1'b0);
    send_pixel(16'd50, 1'b1);

    // scale too large: sextant overflow
    set_bounds(16'd0, 16'd65535, 32'hFFFF_FFFF);
    send_pixel(16'd1, 1'b0);
    send_pixel(16'd2, 1'b0);
    send_pixel(16'd40000, 1'b1);

    set_bounds(16'd0, 16'd65535, 32'd0);
    send_pixel(16'd30000, 1'b1);

    for (int phase = 0; phase < 10; phase++) begin
      mode = (phase == 0) ? 6 : (phase == 9) ? 5 : $urandom_range(0, 9);
      lo = $urandom_range(0, 65534);
      hi = $urandom_range(lo + 1, 65535);
      sc = recip_scale(hi - lo);
      case (mode)
        5: begin
          lo = $urandom_range(0, 65000);
          hi = lo + $urandom_range(1, 16);
          sc = recip_scale(hi - lo);
        end
        6: begin
          lo = 0;
          hi = 65535;
          sc = recip_scale(65535);
        end
        7: hi = lo;
        8: begin
          hi = $urandom_range(0, lo);
          sc = $urandom;
        end
        9: sc = $urandom;
        default: ;
      endcase
      set_bounds(16'(lo), 16'(hi), sc);
      quiet = (phase == 4);
      for (int n = 0; n < 125; n++) begin
        if (phase == 6 && n == 60) drain();
        send_pixel(pick_depth(), ($urandom_range(0, 15) == 0));
      end
      quiet = 1'b0;
    end

    drain();
    repeat (20) @(posedge clk);
    if (chk.errors == 0 && chk.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/dcm_pkg.sv
hdl/dcm_if.sv
hdl/dcm_front.sv
hdl/dcm_hue.sv
hdl/depth_to_color_map_core.sv
sim/tb_top.sv
